// ===== src/rdb_string_header_decoder_macros.svh =====
// assertion macros shared by the decoder modules
// depends on: a clk and an active-low rst_n in the module that expands them
`ifndef RDB_STRING_HEADER_DECODER_MACROS_SVH
`define RDB_STRING_HEADER_DECODER_MACROS_SVH

// check only outside reset
`define RDB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check at every edge, reset included
`define RDB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/rdbshd_pkg.sv =====
// shared types and codes for the string header decoder
// depends on: nothing
package rdbshd_pkg;

    // result kinds as seen on m_axis_tuser
    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_RAW   = 3'd1;
    localparam logic [2:0] KIND_HDR   = 3'd2;
    localparam logic [2:0] KIND_COMP  = 3'd3;
    localparam logic [2:0] KIND_EMPTY = 3'd4;

    // output payload width: integer, byte, packed length, plain length
    localparam int OUT_DATA_W = 104;

    // default depth of the queue between decoder and output stage
    localparam int RDBSHD_QUEUE_DEPTH = 2;

    // compact result record: value holds integer, byte or packed length,
    // aux holds the plain length of a compressed header
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [31:0] aux;
        logic        last;
    } rdbshd_rec_t;

    // decoder to queue push
    typedef struct packed {
        logic        valid;
        rdbshd_rec_t rec;
    } rdbshd_push_t;

endpackage

// ===== src/rdbshd_front.sv =====
// byte decoder: accepts stream bytes and runs the length-prefix state machine
// depends on: rdbshd_pkg, rdb_string_header_decoder_macros.svh
`include "rdb_string_header_decoder_macros.svh"

module rdbshd_front
    import rdbshd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_ready,
    input  logic [7:0]   in_byte,
    output rdbshd_push_t push
);

    // decoder phases
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_LEN14  = 4'd1;
    localparam logic [3:0] PH_LEN32  = 4'd2;
    localparam logic [3:0] PH_RAW    = 4'd3;
    localparam logic [3:0] PH_INT    = 4'd4;
    localparam logic [3:0] PH_CL_PFX = 4'd5;
    localparam logic [3:0] PH_CL_14  = 4'd6;
    localparam logic [3:0] PH_CL_32  = 4'd7;
    localparam logic [3:0] PH_PL_PFX = 4'd8;
    localparam logic [3:0] PH_PL_14  = 4'd9;
    localparam logic [3:0] PH_PL_32  = 4'd10;
    localparam logic [3:0] PH_CBYTES = 4'd11;

    // which length field just completed
    localparam logic [1:0] STG_MAIN   = 2'd0;
    localparam logic [1:0] STG_PACKED = 2'd1;
    localparam logic [1:0] STG_PLAIN  = 2'd2;

    logic [3:0]  phase_reg, phase_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [31:0] gathered_reg, gathered_next;
    logic [2:0]  gather_count_reg, gather_count_next;
    logic [1:0]  int_width_reg, int_width_next;
    logic [31:0] saved_packed_reg, saved_packed_next;

    logic        in_fire;
    logic [1:0]  form;
    logic [5:0]  low;
    logic        len_done;
    logic [1:0]  len_stage;
    logic [31:0] len_value;
    logic [31:0] shifted32;
    logic [31:0] int_or;
    logic [31:0] int_acc;
    logic [2:0]  count_inc;
    logic [2:0]  int_nbytes;
    logic [31:0] bytes_dec;

    assign in_fire   = in_valid && in_ready;
    assign form      = in_byte[7:6];
    assign low       = in_byte[5:0];
    assign shifted32 = {gathered_reg[23:0], in_byte};
    assign count_inc = gather_count_reg + 3'd1;
    assign bytes_dec = bytes_left_reg - 32'd1;

    // little-endian placement of the next integer byte
    always_comb
    begin
        unique case (gather_count_reg[1:0])
            2'd0:    int_or = {24'd0, in_byte};
            2'd1:    int_or = {16'd0, in_byte, 8'd0};
            2'd2:    int_or = {8'd0, in_byte, 16'd0};
            default: int_or = {in_byte, 24'd0};
        endcase
    end
    assign int_acc = gathered_reg | int_or;

    always_comb
    begin
        unique case (int_width_reg)
            2'd0:    int_nbytes = 3'd1;
            2'd1:    int_nbytes = 3'd2;
            default: int_nbytes = 3'd4;
        endcase
    end

    // decoder state machine
    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        gathered_next     = gathered_reg;
        gather_count_next = gather_count_reg;
        int_width_next    = int_width_reg;
        saved_packed_next = saved_packed_reg;
        push              = '0;
        len_done          = 1'b0;
        len_stage         = STG_MAIN;
        len_value         = '0;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    priority if (form == 2'd0)
                    begin
                        len_done  = 1'b1;
                        len_value = {26'd0, low};
                    end
                    else if (form == 2'd1)
                    begin
                        gathered_next = {26'd0, low};
                        phase_next    = PH_LEN14;
                    end
                    else if (form == 2'd2)
                    begin
                        gathered_next     = '0;
                        gather_count_next = '0;
                        phase_next        = PH_LEN32;
                    end
                    else if (low <= 6'd2)
                    begin
                        int_width_next    = low[1:0];
                        gathered_next     = '0;
                        gather_count_next = '0;
                        phase_next        = PH_INT;
                    end
                    else if (low == 6'd3)
                    begin
                        phase_next = PH_CL_PFX;
                    end
                    else
                    begin
                        // unknown special value is read as a raw length
                        len_done  = 1'b1;
                        len_value = {26'd0, low};
                    end
                end
                PH_LEN14, PH_CL_14, PH_PL_14:
                begin
                    len_done  = 1'b1;
                    len_stage = (phase_reg == PH_LEN14) ? STG_MAIN :
                                (phase_reg == PH_CL_14) ? STG_PACKED : STG_PLAIN;
                    len_value = {18'd0, gathered_reg[5:0], in_byte};
                end
                PH_LEN32, PH_CL_32, PH_PL_32:
                begin
                    gathered_next     = shifted32;
                    gather_count_next = count_inc;
                    len_stage = (phase_reg == PH_LEN32) ? STG_MAIN :
                                (phase_reg == PH_CL_32) ? STG_PACKED : STG_PLAIN;
                    len_value = shifted32;
                    len_done  = (count_inc >= 3'd4);
                end
                PH_RAW, PH_CBYTES:
                begin
                    bytes_left_next = bytes_dec;
                    push.valid      = 1'b1;
                    push.rec.kind   = (phase_reg == PH_RAW) ? KIND_RAW : KIND_COMP;
                    push.rec.value  = {24'd0, in_byte};
                    push.rec.last   = (bytes_dec == 32'd0);
                    if (bytes_dec == 32'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_INT:
                begin
                    gathered_next     = int_acc;
                    gather_count_next = count_inc;
                    if (count_inc >= int_nbytes)
                    begin
                        push.valid    = 1'b1;
                        push.rec.kind = KIND_INT;
                        push.rec.last = 1'b1;
                        unique case (int_nbytes)
                            3'd1:    push.rec.value = {{24{int_acc[7]}}, int_acc[7:0]};
                            3'd2:    push.rec.value = {{16{int_acc[15]}}, int_acc[15:0]};
                            default: push.rec.value = int_acc;
                        endcase
                        phase_next = PH_IDLE;
                    end
                end
                PH_CL_PFX, PH_PL_PFX:
                begin
                    // nested prefix; a special form reads as a 6-bit length
                    if (form == 2'd1)
                    begin
                        gathered_next = {26'd0, low};
                        phase_next    = (phase_reg == PH_CL_PFX) ? PH_CL_14 : PH_PL_14;
                    end
                    else if (form == 2'd2)
                    begin
                        gathered_next     = '0;
                        gather_count_next = '0;
                        phase_next        = (phase_reg == PH_CL_PFX) ? PH_CL_32 : PH_PL_32;
                    end
                    else
                    begin
                        len_done  = 1'b1;
                        len_stage = (phase_reg == PH_CL_PFX) ? STG_PACKED : STG_PLAIN;
                        len_value = {26'd0, low};
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // a length field has completed
            if (len_done)
            begin
                unique case (len_stage)
                    STG_MAIN:
                    begin
                        if (len_value == 32'd0)
                        begin
                            push.valid    = 1'b1;
                            push.rec.kind = KIND_EMPTY;
                            push.rec.last = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            bytes_left_next = len_value;
                            phase_next      = PH_RAW;
                        end
                    end
                    STG_PACKED:
                    begin
                        saved_packed_next = len_value;
                        phase_next        = PH_PL_PFX;
                    end
                    default:
                    begin
                        push.valid     = 1'b1;
                        push.rec.kind  = KIND_HDR;
                        push.rec.value = saved_packed_reg;
                        push.rec.aux   = len_value;
                        if (saved_packed_reg == 32'd0)
                        begin
                            push.rec.last = 1'b1;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            bytes_left_next = saved_packed_reg;
                            phase_next      = PH_CBYTES;
                        end
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bytes_left_reg   <= '0;
            gathered_reg     <= '0;
            gather_count_reg <= '0;
            int_width_reg    <= '0;
            saved_packed_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            gathered_reg     <= gathered_next;
            gather_count_reg <= gather_count_next;
            int_width_reg    <= int_width_next;
            saved_packed_reg <= saved_packed_next;
        end
    end

    // payload phases always have bytes outstanding
    `RDB_ASSERT_ALWAYS(a_bytes_left_live,
        (phase_reg == PH_RAW || phase_reg == PH_CBYTES) |-> (bytes_left_reg != 32'd0),
        "payload phase with no bytes left")
    // a result closing an object returns the decoder to idle
    `RDB_ASSERT(a_last_to_idle,
        (push.valid && push.rec.last) |=> (phase_reg == PH_IDLE),
        "object ended but decoder not idle")

endmodule

// ===== src/rdbshd_queue.sv =====
// short queue of result records between decoder and output stage
// depends on: rdbshd_pkg, rdb_string_header_decoder_macros.svh
`include "rdb_string_header_decoder_macros.svh"

module rdbshd_queue
    import rdbshd_pkg::*;
#(
    parameter int DEPTH = RDBSHD_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  rdbshd_push_t push,
    output logic         not_full,
    output logic         head_valid,
    output rdbshd_rec_t  head,
    input  logic         pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rdbshd_rec_t      mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign not_full   = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push.valid;
    assign do_pop     = pop && head_valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

    `RDB_ASSERT(a_count_bound, count_reg <= FULL_CNT, "queue count above depth")
    `RDB_ASSERT(a_no_overflow, !(push.valid && !not_full), "push into full queue")

endmodule

// ===== src/rdbshd_back.sv =====
// output stage: expands result records into stream fields and holds them
// depends on: rdbshd_pkg
module rdbshd_back
    import rdbshd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  rdbshd_rec_t           head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [2:0]            out_kind,
    output logic                  out_last
);

    logic                  valid_reg, valid_next;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [2:0]            kind_reg;
    logic                  last_reg;
    logic [OUT_DATA_W-1:0] data_next;

    assign pop = head_valid && (!valid_reg || out_ready);

    // steer record fields into the output layout, unused fields zero
    always_comb
    begin
        data_next = '0;
        unique case (head.kind)
            KIND_INT:
            begin
                data_next[31:0] = head.value;
            end
            KIND_RAW, KIND_COMP:
            begin
                data_next[39:32] = head.value[7:0];
            end
            KIND_HDR:
            begin
                data_next[71:40]  = head.value;
                data_next[103:72] = head.aux;
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            kind_reg <= head.kind;
            last_reg <= head.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule

// ===== src/rdb_string_header_decoder.sv =====
// Decodes a serialized string object, one byte per cycle, into integer,
// payload-byte and compressed-header results. The input takes a byte every
// cycle while the result queue has room; each byte is consumed by the prefix
// decoder as it is accepted, so the sustained rate is one byte per clock
// while the output keeps accepting results. A result is written into the
// queue and then into the output register; the queue (QUEUE_DEPTH entries)
// and the output register absorb output stalls so the input keeps flowing
// for up to QUEUE_DEPTH + 1 pending results.
// depends on: rdbshd_pkg, rdbshd_front, rdbshd_queue, rdbshd_back
module rdb_string_header_decoder
    import rdbshd_pkg::*;
#(
    parameter int QUEUE_DEPTH = RDBSHD_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // in_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // integer_value, payload_byte, packed_length, plain_length
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]            m_axis_tuser,   // result_kind
    output logic                  m_axis_tlast    // last_of_object
);

    rdbshd_push_t push;
    rdbshd_rec_t  head;
    logic         not_full;
    logic         head_valid;
    logic         pop;

    assign s_axis_tready = not_full;

    // prefix decoder
    rdbshd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (not_full),
        .in_byte  (s_axis_tdata),
        .push     (push)
    );

    // result queue
    rdbshd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .not_full   (not_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // output stage
    rdbshd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_kind   (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule
